// ===== rtl/bcc_pkg.sv =====
// Shared types and codes for the button click classifier.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package bcc_pkg;

  localparam int unsigned TIME_W    = 32;
  localparam int unsigned CFG_IDX_W = 2;

  // Phase codes
  localparam logic [1:0] PHASE_IDLE     = 2'd0;
  localparam logic [1:0] PHASE_PRESSED  = 2'd1;
  localparam logic [1:0] PHASE_RELEASED = 2'd2;
  localparam logic [1:0] PHASE_LONG     = 2'd3;

  // Event codes
  localparam logic [1:0] EVT_NONE   = 2'd0;
  localparam logic [1:0] EVT_SINGLE = 2'd1;
  localparam logic [1:0] EVT_DOUBLE = 2'd2;
  localparam logic [1:0] EVT_LONG   = 2'd3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_CLICK_WINDOW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS_TIME     = 2'd1;

  localparam logic [TIME_W-1:0] DOUBLE_CLICK_WINDOW_RST = 32'd300000;
  localparam logic [TIME_W-1:0] LONG_PRESS_TIME_RST     = 32'd1000000;

  typedef struct packed {
    logic [TIME_W-1:0] double_click_window;
    logic [TIME_W-1:0] long_press_time;
  } bcc_cfg_t;

  typedef struct packed {
    logic [1:0] event_code;
    logic [1:0] button_phase;
  } bcc_result_t;

endpackage

`default_nettype wire

// ===== rtl/bcc_cfg.sv =====
// Configuration register file: double-click window and long-press time.
// Depends on bcc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bcc_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          wr_en,
  input  wire logic [bcc_pkg::CFG_IDX_W-1:0] wr_index,
  input  wire logic [bcc_pkg::TIME_W-1:0]    wr_data,
  output bcc_pkg::bcc_cfg_t                  cfg
);
  import bcc_pkg::*;

  bcc_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.double_click_window <= DOUBLE_CLICK_WINDOW_RST;
      cfg_r.long_press_time     <= LONG_PRESS_TIME_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_DOUBLE_CLICK_WINDOW: cfg_r.double_click_window <= wr_data;
        REG_LONG_PRESS_TIME:     cfg_r.long_press_time     <= wr_data;
        default: ; // unmapped index: ignored
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ===== rtl/bcc_core.sv =====
// Phase machine and last-transition timestamp; one step per accepted poll.
// Depends on bcc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bcc_core (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       step_en,
  input  wire logic                       pin_level,
  input  wire logic [bcc_pkg::TIME_W-1:0] time_now,
  input  bcc_pkg::bcc_cfg_t               cfg,
  output bcc_pkg::bcc_result_t            result
);
  import bcc_pkg::*;

  logic [1:0]        phase_r, phase_nxt;
  logic [TIME_W-1:0] last_t_r, last_t_nxt;
  logic [TIME_W-1:0] elapsed;
  logic [1:0]        evt;
  logic              in_window;
  logic              long_hit;

  // modular difference
  assign elapsed   = time_now - last_t_r;
  assign in_window = elapsed < cfg.double_click_window;
  assign long_hit  = elapsed > cfg.long_press_time;

  always_comb begin
    phase_nxt  = phase_r;
    last_t_nxt = last_t_r;
    evt        = EVT_NONE;
    unique case (phase_r)
      PHASE_IDLE: begin
        if (!in_window && !pin_level) begin
          last_t_nxt = time_now;
          phase_nxt  = PHASE_PRESSED;
        end
      end
      PHASE_PRESSED: begin
        if (long_hit) begin
          last_t_nxt = time_now;
          phase_nxt  = PHASE_LONG;
          evt        = EVT_LONG;
        end else if (pin_level) begin
          last_t_nxt = time_now;
          phase_nxt  = PHASE_RELEASED;
        end
      end
      PHASE_RELEASED: begin
        if (in_window) begin
          if (!pin_level) begin
            last_t_nxt = time_now;
            phase_nxt  = PHASE_IDLE;
            evt        = EVT_DOUBLE;
          end
        end else begin
          last_t_nxt = time_now;
          phase_nxt  = PHASE_IDLE;
          evt        = EVT_SINGLE;
        end
      end
      default: begin
        // long pressed: lockout runs from the long-press report
        if (pin_level) begin
          phase_nxt = PHASE_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PHASE_IDLE;
      last_t_r <= '0;
    end else if (step_en) begin
      phase_r  <= phase_nxt;
      last_t_r <= last_t_nxt;
    end
  end

  assign result.event_code   = evt;
  assign result.button_phase = phase_nxt;

endmodule

`default_nettype wire

// ===== rtl/bcc_outq.sv =====
// Two-entry result queue between the phase logic and the result channel.
// Depends on bcc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bcc_outq (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  bcc_pkg::bcc_result_t push_data,
  output logic               full,
  output logic               pop_valid,
  input  wire logic          pop,
  output bcc_pkg::bcc_result_t pop_data
);
  import bcc_pkg::*;

  bcc_result_t slot_r [2];
  logic        wr_ptr_r;
  logic        rd_ptr_r;
  logic [1:0]  cnt_r;
  logic        do_pop;

  assign full      = cnt_r[1];
  assign pop_valid = cnt_r != 2'd0;
  assign do_pop    = pop && pop_valid;
  assign pop_data  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push)   wr_ptr_r <= ~wr_ptr_r;
      if (do_pop) rd_ptr_r <= ~rd_ptr_r;
      case ({push, do_pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/button_click_classifier.sv =====
// Button click classifier: polls of (pin level, timestamp) in, one
// (event code, phase) beat out per poll.
// Each accepted poll's result is written into a two-entry result queue; throughput
// 1 poll/cycle while the queue has a free entry (in_stall is high when it is full).
// Reset (rst_n low, synchronous): phase idle, last transition time 0,
// registers to 300000 / 1000000 us, result queue empty.
`timescale 1ns / 1ps
`default_nettype none

module button_click_classifier (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // poll channel
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          in_pin_level,
  input  wire logic [bcc_pkg::TIME_W-1:0]    in_time_now,
  // result channel
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [1:0]                         out_event_code,
  output logic [1:0]                         out_button_phase,
  // register write channel
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [bcc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [bcc_pkg::TIME_W-1:0]    cfg_data
);
  import bcc_pkg::*;

  bcc_cfg_t    cfg;
  bcc_result_t step_res;
  bcc_result_t q_res;
  logic        q_full;
  logic        in_accept;

  // Register writes are always taken; software must write only while idle, as the block does not enforce it.
  assign cfg_ready = 1'b1;

  bcc_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // A poll is taken whenever the queue has a free entry, so a new beat
  // can come in while an earlier result still waits downstream.
  assign in_stall  = q_full;
  assign in_accept = in_valid && !q_full;

  // Phase update happens on the accept edge; the result is pushed the
  // same edge and reaches the output behind any results already queued.
  bcc_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (in_accept),
    .pin_level (in_pin_level),
    .time_now  (in_time_now),
    .cfg       (cfg),
    .result    (step_res)
  );

  bcc_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_accept),
    .push_data (step_res),
    .full      (q_full),
    .pop_valid (out_valid),
    .pop       (!out_stall),
    .pop_data  (q_res)
  );

  assign out_event_code   = q_res.event_code;
  assign out_button_phase = q_res.button_phase;

endmodule

`default_nettype wire
